FILE: rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is asserted
`define MVFS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mvfs assertion failed");

// clocked assertion, checked during reset as well
`define MVFS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mvfs assertion failed during reset");

`endif

FILE: rtl/core/mvfs_pkg.sv
`timescale 1ns / 1ps

package mvfs_pkg;

  // header parse phases
  typedef enum logic [4:0] {
    PH_SEARCH = 5'd0,
    PH_HEAD   = 5'd1,
    PH_OLID   = 5'd2,
    PH_OLSKIP = 5'd3,
    PH_ASPECT = 5'd4,
    PH_PAR    = 5'd5,
    PH_CTRL   = 5'd6,
    PH_CHROMA = 5'd7,
    PH_VBVF   = 5'd8,
    PH_VBV    = 5'd9,
    PH_SHAPE  = 5'd10,
    PH_RES    = 5'd11,
    PH_MK1    = 5'd12,
    PH_FIXED  = 5'd13,
    PH_INC    = 5'd14,
    PH_MK2    = 5'd15,
    PH_WID    = 5'd16,
    PH_MK3    = 5'd17,
    PH_HGT    = 5'd18,
    PH_DONE   = 5'd19
  } phase_e;

  localparam int unsigned WindowW  = 24;
  localparam int unsigned CntW     = 7;
  localparam int unsigned AccW     = 16;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned IncW     = 6;

  localparam logic [WindowW-1:0] WindowReset = 24'hFFFFFF;
  localparam logic [WindowW-1:0] StartCode   = 24'h000001;
  localparam logic [WindowW-1:0] WindowRearm = 24'hFFFF00;
  localparam logic [3:0]         VolCodeHi   = 4'h2;
  localparam logic [3:0]         AspectExt   = 4'd15;

  // field lengths in bits
  localparam logic [CntW-1:0] LenHead   = 7'd9;
  localparam logic [CntW-1:0] LenFlag   = 7'd1;
  localparam logic [CntW-1:0] LenOlid   = 7'd7;
  localparam logic [CntW-1:0] LenAspect = 7'd4;
  localparam logic [CntW-1:0] LenPar    = 7'd16;
  localparam logic [CntW-1:0] LenChroma = 7'd3;
  localparam logic [CntW-1:0] LenVbv    = 7'd79;
  localparam logic [CntW-1:0] LenShape  = 7'd3;
  localparam logic [CntW-1:0] LenRes    = 7'd16;
  localparam logic [CntW-1:0] LenSize   = 7'd13;

  // parser state carried from byte to byte
  typedef struct packed {
    phase_e              phase;
    logic [CntW-1:0]     bits_left;
    logic [AccW-1:0]     acc;
    logic [IncW-1:0]     inc_len;
    logic [SizeW-1:0]    width;
  } parse_t;

  // result of consuming one header bit
  typedef struct packed {
    parse_t              st;
    logic                hit;
    logic [SizeW-1:0]    height;
  } step_t;

  // bit length of the vop increment for a given time resolution
  function automatic logic [IncW-1:0] inc_bits(input logic [AccW-1:0] res);
    logic [AccW-1:0] v;
    logic [IncW-1:0] n;
    v = res - AccW'(1);
    n = IncW'(1);
    for (int i = 1; i < AccW; i++) begin
      if (v[i]) n = IncW'(i + 1);
    end
    if (res == '0) n = IncW'(32);
    return n;
  endfunction

  // move to a new field
  function automatic parse_t enter(input parse_t s, input phase_e p,
                                   input logic [CntW-1:0] n);
    parse_t r;
    r = s;
    r.phase     = p;
    r.bits_left = n;
    r.acc       = '0;
    return r;
  endfunction

  // consume one header bit, msb first within the byte
  function automatic step_t take_bit(input parse_t s, input logic b);
    step_t r;
    parse_t t;
    logic [AccW-1:0] a;
    t = s;
    t.acc       = {s.acc[AccW-2:0], b};
    t.bits_left = s.bits_left - CntW'(1);
    a = t.acc;
    r.hit    = 1'b0;
    r.height = '0;
    if (t.bits_left == '0) begin
      unique case (s.phase)
        PH_HEAD:   t = enter(t, PH_OLID, LenFlag);
        PH_OLID:   t = a[0] ? enter(t, PH_OLSKIP, LenOlid) : enter(t, PH_ASPECT, LenAspect);
        PH_OLSKIP: t = enter(t, PH_ASPECT, LenAspect);
        PH_ASPECT: t = (a[3:0] == AspectExt) ? enter(t, PH_PAR, LenPar)
                                             : enter(t, PH_CTRL, LenFlag);
        PH_PAR:    t = enter(t, PH_CTRL, LenFlag);
        PH_CTRL:   t = a[0] ? enter(t, PH_CHROMA, LenChroma) : enter(t, PH_SHAPE, LenShape);
        PH_CHROMA: t = enter(t, PH_VBVF, LenFlag);
        PH_VBVF:   t = a[0] ? enter(t, PH_VBV, LenVbv) : enter(t, PH_SHAPE, LenShape);
        PH_VBV:    t = enter(t, PH_SHAPE, LenShape);
        PH_SHAPE:  t = enter(t, PH_RES, LenRes);
        PH_RES: begin
          t.inc_len = inc_bits(a);
          t = enter(t, PH_MK1, LenFlag);
        end
        PH_MK1:    t = enter(t, PH_FIXED, LenFlag);
        PH_FIXED:  t = a[0] ? enter(t, PH_INC, CntW'(t.inc_len)) : enter(t, PH_MK2, LenFlag);
        PH_INC:    t = enter(t, PH_MK2, LenFlag);
        PH_MK2:    t = enter(t, PH_WID, LenSize);
        PH_WID: begin
          t.width = a[SizeW-1:0];
          t = enter(t, PH_MK3, LenFlag);
        end
        PH_MK3:    t = enter(t, PH_HGT, LenSize);
        PH_HGT: begin
          r.hit    = 1'b1;
          r.height = a[SizeW-1:0];
          t = enter(t, PH_DONE, '0);
        end
        default:   t = enter(t, PH_DONE, '0);
      endcase
    end
    r.st = t;
    return r;
  endfunction

endpackage

FILE: rtl/core/mpeg4_vol_frame_size_extract.sv
`timescale 1ns / 1ps
// dataflow: a byte is taken into the input register, parsed eight bits at a time, and any
//   result is loaded into the output register once the result slot is free
// throughput: one byte per cycle while no stalled result holds the result slot
// reset (rst_ni low, asynchronous): search for start code, no result pending
// a byte with last_byte set rearms the search after it is parsed
module mpeg4_vol_frame_size_extract (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [12:0] frame_width_o,
  output logic [12:0] frame_height_o
);

  localparam mvfs_pkg::parse_t ParseReset = '{
    phase:     mvfs_pkg::PH_SEARCH,
    bits_left: '0,
    acc:       '0,
    inc_len:   '0,
    width:     '0
  };

  logic                            in_valid_q;
  logic [7:0]                      byte_q;
  logic                            last_q;
  logic                            advance;
  logic                            in_xfer;

  mvfs_pkg::parse_t                st_q, st_d;
  logic [mvfs_pkg::WindowW-1:0]    window_q, window_d;
  logic                            reported_q, reported_d;

  logic                            produce;
  logic                            res_found;
  logic [mvfs_pkg::SizeW-1:0]      res_width, res_height;

  logic                            out_valid_q;
  logic                            found_q;
  logic [mvfs_pkg::SizeW-1:0]      width_q, height_q;

  // handshake: the input register moves whenever the result slot is free
  assign advance    = in_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // start code search and eight-bit header parse
  always_comb begin
    mvfs_pkg::step_t stp;
    stp        = '0;
    st_d       = st_q;
    window_d   = window_q;
    reported_d = reported_q;
    produce    = 1'b0;
    res_found  = 1'b0;
    res_width  = '0;
    res_height = '0;
    if (st_q.phase == mvfs_pkg::PH_SEARCH) begin
      if (window_q == mvfs_pkg::StartCode) begin
        if (byte_q[7:4] == mvfs_pkg::VolCodeHi) begin
          st_d = mvfs_pkg::enter(st_q, mvfs_pkg::PH_HEAD, mvfs_pkg::LenHead);
        end else begin
          window_d = mvfs_pkg::WindowRearm | mvfs_pkg::WindowW'(byte_q);
        end
      end else begin
        window_d = {window_q[mvfs_pkg::WindowW-9:0], byte_q};
      end
    end else begin
      for (int i = 7; i >= 0; i--) begin
        if (st_d.phase != mvfs_pkg::PH_DONE) begin
          stp  = mvfs_pkg::take_bit(st_d, byte_q[i]);
          st_d = stp.st;
          if (stp.hit) begin
            produce    = 1'b1;
            res_found  = 1'b1;
            res_width  = stp.st.width;
            res_height = stp.height;
            reported_d = 1'b1;
          end
        end
      end
    end
    // end of buffer: report not found once, then rearm
    if (last_q) begin
      if (!produce && !reported_q) begin
        produce = 1'b1;
      end
      st_d       = ParseReset;
      window_d   = mvfs_pkg::WindowReset;
      reported_d = 1'b0;
    end
  end

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ParseReset;
      window_q   <= mvfs_pkg::WindowReset;
      reported_q <= 1'b0;
    end else if (advance) begin
      st_q       <= st_d;
      window_q   <= window_d;
      reported_q <= reported_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= produce;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      found_q  <= res_found;
      width_q  <= res_width;
      height_q <= res_height;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign frame_width_o  = width_q;
  assign frame_height_o = height_q;

endmodule

FILE: rtl/core/mvfs_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mvfs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        found_o,
  input logic [12:0] frame_width_o,
  input logic [12:0] frame_height_o
);

  // a not-found result carries zero sizes
  `MVFS_ASSERT(a_notfound_zero, out_valid_o && !found_o |-> frame_width_o == '0 && frame_height_o == '0)

  // a stalled result holds
  `MVFS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o) && $stable(frame_width_o) && $stable(frame_height_o))

  // input side backs up only behind a stalled pending result
  `MVFS_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

  // nothing is offered or held back while in reset
  `MVFS_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o && !in_stall_o)

endmodule

bind mpeg4_vol_frame_size_extract mvfs_checker u_mvfs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .found_o        (found_o),
  .frame_width_o  (frame_width_o),
  .frame_height_o (frame_height_o)
);
